### src/olsm_pkg.sv
`default_nettype none
package olsm_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_MARK   = 2'd2,
    OP_PURGE  = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DROPPED   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SWEEP,
    ST_COMPACT,
    ST_WRITE,
    ST_DONE
  } state_t;

  // command broadcast to every cell
  typedef struct packed {
    op_t  op;
    logic write_en;
    logic compact_en;
    logic phase;
  } cmd_t;

  // flags carried by the scan token along the chain
  typedef struct packed {
    logic active;
    logic found;
    logic evict_done;
    logic hit;
    logic unsent_dec;
  } tok_t;

endpackage
`default_nettype wire

### src/olsm_in_if.sv
`default_nettype none
interface olsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] entry_payload;
  logic [4:0]  position;

  modport source (output valid, output operation, output entry_payload, output position,
                  input ready);
  modport sink (input valid, input operation, input entry_payload, input position,
                output ready);
endinterface
`default_nettype wire

### src/olsm_out_if.sv
`default_nettype none
interface olsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] found_payload;
  logic [4:0]  found_slot;
  logic [5:0]  unsent_total;
  logic [5:0]  entry_total;

  modport source (output valid, output status, output found_payload, output found_slot,
                  output unsent_total, output entry_total, input ready);
  modport sink (input valid, input status, input found_payload, input found_slot,
                input unsent_total, input entry_total, output ready);
endinterface
`default_nettype wire

### src/ordered_log_with_sent_marks.sv
`default_nettype none
// sequence: an append with room goes through the write state to the result register; get, mark and
// an append dropped on a full log launch one scan token that walks the cell chain, one cell per cycle;
// purge scans, then runs LOG_DEPTH compaction phases, and an append that evicts scans, compacts
// through LOG_DEPTH phases, then writes.
// throughput: one word at a time; the next word is taken once the result is registered.
// reset: synchronous active-low rst_n empties the log, clears all sent marks and counts.
module ordered_log_with_sent_marks #(
  parameter int LOG_DEPTH    = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  olsm_in_if.sink    in_chan,
  olsm_out_if.source out_chan
);

  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int IW = $clog2(LOG_DEPTH);
  localparam int WW = (CW > 5) ? CW : 5;
  localparam int PB = PAYLOAD_BITS;

  olsm_pkg::state_t state_r, state_nxt;
  olsm_pkg::op_t    op_r, op_nxt;
  logic [PB-1:0]    pay_r, pay_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    unsent_r, unsent_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [PB-1:0]    res_pay_r, res_pay_nxt;
  logic [4:0]       res_slot_r, res_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [63:0]      out_pay_r, out_pay_nxt;
  logic [4:0]       out_slot_r, out_slot_nxt;
  logic [5:0]       out_unsent_r, out_unsent_nxt;
  logic [5:0]       out_total_r, out_total_nxt;

  logic             accept;
  logic             out_free;
  olsm_pkg::cmd_t   cmd;

  logic           valid_w [LOG_DEPTH];
  logic           sent_w  [LOG_DEPTH];
  logic [PB-1:0]  pay_w   [LOG_DEPTH];
  olsm_pkg::tok_t tok_w   [LOG_DEPTH+1];
  logic [WW-1:0]  seen_w  [LOG_DEPTH+1];
  logic [PB-1:0]  fpay_w  [LOG_DEPTH+1];
  logic [WW-1:0]  fslot_w [LOG_DEPTH+1];

  olsm_pkg::tok_t tok_last;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign tok_last = tok_w[LOG_DEPTH];

  assign cmd.op         = op_r;
  assign cmd.write_en   = state_r == olsm_pkg::ST_WRITE;
  assign cmd.compact_en = state_r == olsm_pkg::ST_COMPACT;
  assign cmd.phase      = cnt_r[0];

  // active is the top field of the token, all other flags start clear
  assign tok_w[0]   = {state_r == olsm_pkg::ST_LAUNCH, 4'b0000};
  assign seen_w[0]  = '0;
  assign fpay_w[0]  = '0;
  assign fslot_w[0] = '0;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    logic          lo_valid;
    logic          hi_valid;
    logic          hi_sent;
    logic [PB-1:0] hi_pay;

    if (i > 0) begin : g_lo
      assign lo_valid = valid_w[i-1];
    end else begin : g_lo_edge
      assign lo_valid = 1'b1;
    end

    if (i + 1 < LOG_DEPTH) begin : g_hi
      assign hi_valid = valid_w[i+1];
      assign hi_sent  = sent_w[i+1];
      assign hi_pay   = pay_w[i+1];
    end else begin : g_hi_edge
      assign hi_valid = 1'b0;
      assign hi_sent  = 1'b0;
      assign hi_pay   = '0;
    end

    olsm_cell #(
      .IDX   (i),
      .DEPTH (LOG_DEPTH),
      .PB    (PB),
      .WW    (WW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .pos       (pos_r),
      .wr_pay    (pay_r),
      .wr_idx    (WW'(count_r)),
      .lo_valid  (lo_valid),
      .hi_valid  (hi_valid),
      .hi_sent   (hi_sent),
      .hi_pay    (hi_pay),
      .tok_in    (tok_w[i]),
      .seen_in   (seen_w[i]),
      .fpay_in   (fpay_w[i]),
      .fslot_in  (fslot_w[i]),
      .valid     (valid_w[i]),
      .sent      (sent_w[i]),
      .pay       (pay_w[i]),
      .tok_out   (tok_w[i+1]),
      .seen_out  (seen_w[i+1]),
      .fpay_out  (fpay_w[i+1]),
      .fslot_out (fslot_w[i+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olsm_pkg::ST_IDLE: begin
        if (accept) begin
          if (olsm_pkg::op_t'(in_chan.operation) == olsm_pkg::OP_APPEND &&
              count_r < CW'(LOG_DEPTH))
            state_nxt = olsm_pkg::ST_WRITE;
          else
            state_nxt = olsm_pkg::ST_LAUNCH;
        end
      end
      olsm_pkg::ST_LAUNCH: state_nxt = olsm_pkg::ST_SWEEP;
      olsm_pkg::ST_SWEEP: begin
        if (tok_last.active) begin
          if (op_r == olsm_pkg::OP_PURGE ||
              (op_r == olsm_pkg::OP_APPEND && tok_last.evict_done))
            state_nxt = olsm_pkg::ST_COMPACT;
          else
            state_nxt = olsm_pkg::ST_DONE;
        end
      end
      olsm_pkg::ST_COMPACT: begin
        if (cnt_r == IW'(LOG_DEPTH - 1))
          state_nxt = (op_r == olsm_pkg::OP_APPEND) ? olsm_pkg::ST_WRITE : olsm_pkg::ST_DONE;
      end
      olsm_pkg::ST_WRITE: state_nxt = olsm_pkg::ST_DONE;
      olsm_pkg::ST_DONE: begin
        if (out_free) state_nxt = olsm_pkg::ST_IDLE;
      end
      default: state_nxt = olsm_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt         = op_r;
    pay_nxt        = pay_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    unsent_nxt     = unsent_r;
    cnt_nxt        = '0;
    res_status_nxt = res_status_r;
    res_pay_nxt    = res_pay_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_pay_nxt    = out_pay_r;
    out_slot_nxt   = out_slot_r;
    out_unsent_nxt = out_unsent_r;
    out_total_nxt  = out_total_r;

    case (state_r)
      olsm_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = olsm_pkg::op_t'(in_chan.operation);
          pay_nxt        = in_chan.entry_payload[PB-1:0];
          pos_nxt        = in_chan.position;
          res_status_nxt = olsm_pkg::STATUS_OK;
          res_pay_nxt    = '0;
          res_slot_nxt   = '0;
        end
      end
      olsm_pkg::ST_SWEEP: begin
        if (tok_last.active) begin
          case (op_r)
            olsm_pkg::OP_APPEND: begin
              if (tok_last.evict_done) count_nxt = count_r - 1'b1;
              else res_status_nxt = olsm_pkg::STATUS_DROPPED;
            end
            olsm_pkg::OP_GET: begin
              if (tok_last.found) begin
                res_pay_nxt  = fpay_w[LOG_DEPTH];
                res_slot_nxt = fslot_w[LOG_DEPTH][4:0];
              end else begin
                res_status_nxt = olsm_pkg::STATUS_NOT_FOUND;
              end
            end
            olsm_pkg::OP_MARK: begin
              if (!tok_last.hit) res_status_nxt = olsm_pkg::STATUS_NOT_FOUND;
              if (tok_last.unsent_dec) unsent_nxt = unsent_r - 1'b1;
            end
            olsm_pkg::OP_PURGE: count_nxt = unsent_r;
            default: ;
          endcase
        end
      end
      olsm_pkg::ST_COMPACT: cnt_nxt = cnt_r + 1'b1;
      olsm_pkg::ST_WRITE: begin
        count_nxt  = count_r + 1'b1;
        unsent_nxt = unsent_r + 1'b1;
      end
      olsm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pay_nxt    = 64'(res_pay_r);
          out_slot_nxt   = res_slot_r;
          out_unsent_nxt = 6'(unsent_r);
          out_total_nxt  = 6'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olsm_pkg::ST_IDLE;
      count_r     <= '0;
      unsent_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      unsent_r    <= unsent_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pay_r        <= pay_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
    out_slot_r   <= out_slot_nxt;
    out_unsent_r <= out_unsent_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign in_chan.ready          = state_r == olsm_pkg::ST_IDLE;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.found_payload = out_pay_r;
  assign out_chan.found_slot    = out_slot_r;
  assign out_chan.unsent_total  = out_unsent_r;
  assign out_chan.entry_total   = out_total_r;

endmodule
`default_nettype wire

### src/olsm_cell.sv
`default_nettype none
module olsm_cell #(
  parameter int IDX   = 0,
  parameter int DEPTH = 32,
  parameter int PB    = 64,
  parameter int WW    = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire olsm_pkg::cmd_t    cmd,
  input  wire logic [4:0]        pos,
  input  wire logic [PB-1:0]     wr_pay,
  input  wire logic [WW-1:0]     wr_idx,
  input  wire logic              lo_valid,
  input  wire logic              hi_valid,
  input  wire logic              hi_sent,
  input  wire logic [PB-1:0]     hi_pay,
  input  wire olsm_pkg::tok_t    tok_in,
  input  wire logic [WW-1:0]     seen_in,
  input  wire logic [PB-1:0]     fpay_in,
  input  wire logic [WW-1:0]     fslot_in,
  output logic                   valid,
  output logic                   sent,
  output logic [PB-1:0]          pay,
  output olsm_pkg::tok_t         tok_out,
  output logic [WW-1:0]          seen_out,
  output logic [PB-1:0]          fpay_out,
  output logic [WW-1:0]          fslot_out
);

  localparam logic [WW-1:0] MY_IDX = WW'(IDX);
  localparam logic          PARITY = (IDX % 2) == 1;
  localparam bit            HAS_HI = (IDX + 1) < DEPTH;
  localparam bit            HAS_LO = IDX > 0;

  logic           valid_r, valid_nxt;
  logic           sent_r, sent_nxt;
  logic [PB-1:0]  pay_r, pay_nxt;
  olsm_pkg::tok_t tok_r, tok_nxt;
  logic [WW-1:0]  seen_r, seen_nxt;
  logic [PB-1:0]  fpay_r, fpay_nxt;
  logic [WW-1:0]  fslot_r, fslot_nxt;

  always_comb begin
    valid_nxt = valid_r;
    sent_nxt  = sent_r;
    pay_nxt   = pay_r;
    tok_nxt   = tok_in;
    seen_nxt  = seen_in;
    fpay_nxt  = fpay_in;
    fslot_nxt = fslot_in;

    if (tok_in.active) begin
      case (cmd.op)
        olsm_pkg::OP_GET: begin
          if (valid_r && !sent_r) begin
            if (!tok_in.found && seen_in == WW'(pos)) begin
              tok_nxt.found = 1'b1;
              fpay_nxt      = pay_r;
              fslot_nxt     = MY_IDX;
            end
            seen_nxt = seen_in + 1'b1;
          end
        end
        olsm_pkg::OP_MARK: begin
          if (valid_r && WW'(pos) == MY_IDX) begin
            tok_nxt.hit = 1'b1;
            if (!sent_r) begin
              tok_nxt.unsent_dec = 1'b1;
              sent_nxt           = 1'b1;
            end
          end
        end
        olsm_pkg::OP_APPEND: begin
          // first sent entry seen becomes a hole
          if (valid_r && sent_r && !tok_in.evict_done) begin
            tok_nxt.evict_done = 1'b1;
            valid_nxt          = 1'b0;
          end
        end
        olsm_pkg::OP_PURGE: begin
          if (valid_r && sent_r) valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    // odd-even transposition moves holes up, entries keep their order
    if (cmd.compact_en) begin
      if (HAS_HI && PARITY == cmd.phase && !valid_r && hi_valid) begin
        valid_nxt = 1'b1;
        sent_nxt  = hi_sent;
        pay_nxt   = hi_pay;
      end
      if (HAS_LO && PARITY != cmd.phase && !lo_valid && valid_r) begin
        valid_nxt = 1'b0;
      end
    end

    if (cmd.write_en && wr_idx == MY_IDX) begin
      valid_nxt = 1'b1;
      sent_nxt  = 1'b0;
      pay_nxt   = wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      sent_r  <= sent_nxt;
      tok_r   <= tok_nxt;
    end
    pay_r   <= pay_nxt;
    seen_r  <= seen_nxt;
    fpay_r  <= fpay_nxt;
    fslot_r <= fslot_nxt;
  end

  assign valid     = valid_r;
  assign sent      = sent_r;
  assign pay       = pay_r;
  assign tok_out   = tok_r;
  assign seen_out  = seen_r;
  assign fpay_out  = fpay_r;
  assign fslot_out = fslot_r;

endmodule
`default_nettype wire
